FILE: sv/lbcs_pkg.sv
// Shared constants, types and helpers for the LDS bank conflict scorer.
package lbcs_pkg;

   localparam int BANK_COUNT      = 64;
   localparam int BANK_BYTES      = 4;
   localparam int MAX_BATCH_WORDS = 128;
   localparam int MEM_BYTES       = 65536;

   localparam int OFFSET_W    = $clog2(MEM_BYTES);
   localparam int WORD_W      = $clog2(MEM_BYTES / BANK_BYTES);
   localparam int BYTE_SEL_W  = $clog2(BANK_BYTES);
   localparam int BANK_IDX_W  = $clog2(BANK_COUNT);
   localparam int BANK_SCAN_W = $clog2(BANK_COUNT + 1);
   localparam int TABLE_IDX_W = $clog2(MAX_BATCH_WORDS);
   localparam int COUNT_W     = $clog2(MAX_BATCH_WORDS + 1);
   localparam int MULT_W      = 8;
   localparam int SUM_W       = 24;
   localparam int TAG_W       = 12;
   localparam int SIZE_W      = 2;

   localparam logic [MULT_W-1:0] MULT_MAX = {MULT_W{1'b1}};
   localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

   // access size codes
   localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
   localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;

   // register map: index taken from the word address bit of paddr
   localparam int   CSR_ADDR_W      = 3;
   localparam logic CSR_ACCESS_SIZE = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_INSERT,
      ST_BANK_UPD,
      ST_CLOSE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [MULT_W-1:0] mult;
      logic [SUM_W-1:0]  serial;
      logic [SUM_W-1:0]  conf;
   } score_type;

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [MULT_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {{(SUM_W + 1 - MULT_W){1'b0}}, b};
      sat_add = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
   endfunction

endpackage

FILE: sv/lbcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lbcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: sv/lds_bank_conflict_scorer.sv
// Top level of the LDS bank conflict scorer: sequencer, word table and bank counters.
// Per transaction: an accept in the idle state, then per covered word a table scan and, for a word
// not yet in the table, an insert and a bank counter bump (no bump, only an overflow flag, when full).
// A closing transaction adds a sweep over all BANK_COUNT bank counters and a result state.
// One transaction at a time: req_ready is high only while the sequencer is idle.
// Synchronous reset clears control state; bank counters are masked by per-bank valid bits.
module lds_bank_conflict_scorer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lbcs_pkg::OFFSET_W-1:0]        req_byte_offset,
   input  logic                                 req_batch_last,
   input  logic                                 req_layout_last,
   input  logic                                 req_search_start,
   input  logic [lbcs_pkg::TAG_W-1:0]           req_layout_tag,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [lbcs_pkg::MULT_W-1:0]          rsp_max_multiplicity,
   output logic [lbcs_pkg::SUM_W-1:0]           rsp_serialized_words,
   output logic [lbcs_pkg::SUM_W-1:0]           rsp_conflicting_banks,
   output logic                                 rsp_is_layout_end,
   output logic [lbcs_pkg::TAG_W-1:0]           rsp_best_tag,
   output logic                                 rsp_new_best,
   output logic                                 rsp_overflow,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [lbcs_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import lbcs_pkg::*;

   state_type state_ff, state_in;

   logic [SIZE_W-1:0]     access_size_ff, access_size_in;

   logic [WORD_W-1:0]     word_ff, word_in;
   logic [WORD_W-1:0]     word2_ff, word2_in;
   logic                  has_word2_ff, has_word2_in;
   logic                  close_ff, close_in;
   logic                  layout_last_ff, layout_last_in;
   logic [TAG_W-1:0]      tag_ff, tag_in;

   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  overflow_ff, overflow_in;
   logic [BANK_COUNT-1:0] bank_valid_ff, bank_valid_in;
   logic [COUNT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic [BANK_SCAN_W-1:0] bank_idx_ff, bank_idx_in;
   logic [BANK_IDX_W-1:0] bank_prev_ff, bank_prev_in;

   score_type             run_ff, run_in;
   score_type             best_ff, best_in;
   logic                  best_valid_ff, best_valid_in;
   logic [TAG_W-1:0]      best_tag_ff, best_tag_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   score_type             rsp_score_ff, rsp_score_in;
   logic                  rsp_layout_end_ff, rsp_layout_end_in;
   logic [TAG_W-1:0]      rsp_best_tag_ff, rsp_best_tag_in;
   logic                  rsp_new_best_ff, rsp_new_best_in;
   logic                  rsp_overflow_ff, rsp_overflow_in;

   logic                  req_accept;
   logic                  csr_write;
   logic                  scan_hit;
   logic                  scan_more;
   logic                  table_full;
   logic                  close_done;
   logic                  result_go;
   logic                  beats_best;
   state_type             after_word;

   logic [BYTE_SEL_W-1:0] bytes_m1;
   logic [OFFSET_W:0]     last_sum;
   logic [WORD_W-1:0]     lo_word;
   logic [WORD_W-1:0]     hi_word;

   logic                  word_wr_en;
   logic [TABLE_IDX_W-1:0] word_rd_addr;
   logic [WORD_W-1:0]     word_rd_data;
   logic                  bank_wr_en;
   logic [BANK_IDX_W-1:0] bank_wr_addr;
   logic [MULT_W-1:0]     bank_wr_data;
   logic [BANK_IDX_W-1:0] bank_rd_addr;
   logic [MULT_W-1:0]     bank_rd_data;
   logic [MULT_W-1:0]     upd_count;
   logic [MULT_W-1:0]     sweep_count;

   lbcs_ram #(.WIDTH(WORD_W), .DEPTH(MAX_BATCH_WORDS)) u_word_ram (
      .clock   (clock),
      .wr_en   (word_wr_en),
      .wr_addr (count_ff[TABLE_IDX_W-1:0]),
      .wr_data (word_ff),
      .rd_addr (word_rd_addr),
      .rd_data (word_rd_data)
   );

   lbcs_ram #(.WIDTH(MULT_W), .DEPTH(BANK_COUNT)) u_bank_ram (
      .clock   (clock),
      .wr_en   (bank_wr_en),
      .wr_addr (bank_wr_addr),
      .wr_data (bank_wr_data),
      .rd_addr (bank_rd_addr),
      .rd_data (bank_rd_data)
   );

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr[CSR_ADDR_W-1] == CSR_ACCESS_SIZE) ?
                      {{(32 - SIZE_W){1'b0}}, access_size_ff} : 32'd0;

   always_comb begin
      access_size_in = access_size_ff;
      if (csr_write && paddr[CSR_ADDR_W-1] == CSR_ACCESS_SIZE) begin
         access_size_in = pwdata[SIZE_W-1:0];
      end
   end

   // address decode of the incoming transaction
   always_comb begin
      case (access_size_ff)
         SIZE_BYTE: bytes_m1 = BYTE_SEL_W'(0);
         SIZE_HALF: bytes_m1 = BYTE_SEL_W'(1);
         default:   bytes_m1 = BYTE_SEL_W'(BANK_BYTES - 1);
      endcase
   end

   assign last_sum = {1'b0, req_byte_offset} + {{(OFFSET_W + 1 - BYTE_SEL_W){1'b0}}, bytes_m1};
   assign lo_word  = req_byte_offset[OFFSET_W-1:BYTE_SEL_W];
   assign hi_word  = last_sum[OFFSET_W-1:BYTE_SEL_W];

   // sequencer status
   assign req_ready   = (state_ff == ST_IDLE);
   assign req_accept  = req_valid && req_ready;
   assign scan_hit    = cmp_valid_ff && (word_rd_data == word_ff);
   assign scan_more   = (scan_idx_ff < count_ff);
   assign table_full  = (count_ff >= COUNT_W'(MAX_BATCH_WORDS));
   assign close_done  = (bank_idx_ff == BANK_SCAN_W'(BANK_COUNT)) && !cmp_valid_ff;
   assign result_go   = (state_ff == ST_RESULT) && (!rsp_valid_ff || rsp_ready);
   assign beats_best  = !best_valid_ff || (run_ff < best_ff);
   assign after_word  = has_word2_ff ? ST_SCAN : (close_ff ? ST_CLOSE : ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_hit) begin
               state_in = after_word;
            end else if (!scan_more) begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            state_in = table_full ? after_word : ST_BANK_UPD;
         end
         ST_BANK_UPD: begin
            state_in = after_word;
         end
         ST_CLOSE: begin
            if (close_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (result_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory port control
   assign upd_count    = bank_valid_ff[word_ff[BANK_IDX_W-1:0]] ? bank_rd_data : '0;
   assign sweep_count  = bank_valid_ff[bank_prev_ff] ? bank_rd_data : '0;

   always_comb begin
      word_rd_addr = scan_idx_ff[TABLE_IDX_W-1:0];
      word_wr_en   = 1'b0;
      bank_rd_addr = bank_idx_ff[BANK_IDX_W-1:0];
      bank_wr_en   = 1'b0;
      bank_wr_addr = word_ff[BANK_IDX_W-1:0];
      bank_wr_data = (upd_count == MULT_MAX) ? MULT_MAX : upd_count + MULT_W'(1);
      case (state_ff)
         ST_INSERT: begin
            word_wr_en   = !table_full;
            bank_rd_addr = word_ff[BANK_IDX_W-1:0];
         end
         ST_BANK_UPD: begin
            bank_wr_en = 1'b1;
         end
         default: begin
            word_wr_en = 1'b0;
            bank_wr_en = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      word_in           = word_ff;
      word2_in          = word2_ff;
      has_word2_in      = has_word2_ff;
      close_in          = close_ff;
      layout_last_in    = layout_last_ff;
      tag_in            = tag_ff;
      count_in          = count_ff;
      overflow_in       = overflow_ff;
      bank_valid_in     = bank_valid_ff;
      scan_idx_in       = scan_idx_ff;
      cmp_valid_in      = cmp_valid_ff;
      bank_idx_in       = bank_idx_ff;
      bank_prev_in      = bank_prev_ff;
      run_in            = run_ff;
      best_in           = best_ff;
      best_valid_in     = best_valid_ff;
      best_tag_in       = best_tag_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_score_in      = rsp_score_ff;
      rsp_layout_end_in = rsp_layout_end_ff;
      rsp_best_tag_in   = rsp_best_tag_ff;
      rsp_new_best_in   = rsp_new_best_ff;
      rsp_overflow_in   = rsp_overflow_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               word_in        = lo_word;
               word2_in       = hi_word;
               has_word2_in   = (hi_word != lo_word);
               close_in       = req_batch_last || req_layout_last;
               layout_last_in = req_layout_last;
               tag_in         = req_layout_tag;
               scan_idx_in    = '0;
               cmp_valid_in   = 1'b0;
               if (req_search_start) begin
                  best_valid_in = 1'b0;
                  best_tag_in   = '0;
                  best_in       = '0;
                  run_in        = '{mult: MULT_W'(1), serial: '0, conf: '0};
                  count_in      = '0;
                  overflow_in   = 1'b0;
                  bank_valid_in = '0;
               end
            end
         end
         ST_SCAN: begin
            cmp_valid_in = 1'b0;
            if (!scan_hit && scan_more) begin
               scan_idx_in  = scan_idx_ff + COUNT_W'(1);
               cmp_valid_in = 1'b1;
            end
         end
         ST_INSERT: begin
            if (table_full) begin
               overflow_in = 1'b1;
            end else begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
         ST_BANK_UPD: begin
            bank_valid_in[word_ff[BANK_IDX_W-1:0]] = 1'b1;
         end
         ST_CLOSE: begin
            if (cmp_valid_ff) begin
               if (sweep_count > run_ff.mult) begin
                  run_in.mult = sweep_count;
               end
               if (sweep_count > MULT_W'(1)) begin
                  run_in.serial = sat_add(run_ff.serial, sweep_count - MULT_W'(1));
                  run_in.conf   = sat_add(run_ff.conf, MULT_W'(1));
               end
            end
            cmp_valid_in = 1'b0;
            if (bank_idx_ff < BANK_SCAN_W'(BANK_COUNT)) begin
               bank_prev_in = bank_idx_ff[BANK_IDX_W-1:0];
               bank_idx_in  = bank_idx_ff + BANK_SCAN_W'(1);
               cmp_valid_in = 1'b1;
            end
         end
         ST_RESULT: begin
            if (result_go) begin
               rsp_valid_in      = 1'b1;
               rsp_score_in      = run_ff;
               rsp_layout_end_in = layout_last_ff;
               rsp_overflow_in   = overflow_ff;
               rsp_new_best_in   = 1'b0;
               rsp_best_tag_in   = best_tag_ff;
               count_in          = '0;
               overflow_in       = 1'b0;
               bank_valid_in     = '0;
               if (layout_last_ff) begin
                  if (beats_best) begin
                     best_valid_in   = 1'b1;
                     best_in         = run_ff;
                     best_tag_in     = tag_ff;
                     rsp_best_tag_in = tag_ff;
                     rsp_new_best_in = 1'b1;
                  end
                  run_in = '{mult: MULT_W'(1), serial: '0, conf: '0};
               end
            end
         end
         default: begin
            cmp_valid_in = 1'b0;
         end
      endcase

      // move on to the second word or the batch close
      if ((state_ff == ST_SCAN && scan_hit) || (state_ff == ST_INSERT && table_full) ||
          state_ff == ST_BANK_UPD) begin
         cmp_valid_in = 1'b0;
         if (has_word2_ff) begin
            word_in      = word2_ff;
            has_word2_in = 1'b0;
            scan_idx_in  = '0;
         end else begin
            bank_idx_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         access_size_ff <= SIZE_BYTE;
         count_ff       <= '0;
         overflow_ff    <= 1'b0;
         bank_valid_ff  <= '0;
         cmp_valid_ff   <= 1'b0;
         run_ff         <= '{mult: MULT_W'(1), serial: '0, conf: '0};
         best_ff        <= '0;
         best_valid_ff  <= 1'b0;
         best_tag_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         access_size_ff <= access_size_in;
         count_ff       <= count_in;
         overflow_ff    <= overflow_in;
         bank_valid_ff  <= bank_valid_in;
         cmp_valid_ff   <= cmp_valid_in;
         run_ff         <= run_in;
         best_ff        <= best_in;
         best_valid_ff  <= best_valid_in;
         best_tag_ff    <= best_tag_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff           <= word_in;
      word2_ff          <= word2_in;
      has_word2_ff      <= has_word2_in;
      close_ff          <= close_in;
      layout_last_ff    <= layout_last_in;
      tag_ff            <= tag_in;
      scan_idx_ff       <= scan_idx_in;
      bank_idx_ff       <= bank_idx_in;
      bank_prev_ff      <= bank_prev_in;
      rsp_score_ff      <= rsp_score_in;
      rsp_layout_end_ff <= rsp_layout_end_in;
      rsp_best_tag_ff   <= rsp_best_tag_in;
      rsp_new_best_ff   <= rsp_new_best_in;
      rsp_overflow_ff   <= rsp_overflow_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_max_multiplicity  = rsp_score_ff.mult;
   assign rsp_serialized_words  = rsp_score_ff.serial;
   assign rsp_conflicting_banks = rsp_score_ff.conf;
   assign rsp_is_layout_end     = rsp_layout_end_ff;
   assign rsp_best_tag          = rsp_best_tag_ff;
   assign rsp_new_best          = rsp_new_best_ff;
   assign rsp_overflow          = rsp_overflow_ff;

endmodule
